FILE: src/assert_macros.svh
// Assertion helpers for the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, switched off while reset is high.
`define VHTM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define VHTM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VHTM_ASSERT(name, clk, rst, prop, msg)
`define VHTM_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: src/vhtm_pkg.sv
package vhtm_pkg;

  localparam int NOISY_DEPTH_DEF = 8;
  localparam int MAX_MATCHES_DEF = 128;
  localparam int MAX_HITS_DEF    = 1024;
  localparam int STATIONS_DEF    = 12;

  localparam int FUNC_W    = 2;
  localparam int STATION_W = 4;
  localparam int CHAN_W    = 17;
  localparam int TIME_W    = 31;
  localparam int DELTA_W   = 32;
  localparam int EDGE_W    = 4;
  localparam int SLOT_W    = 3;
  localparam int WIN_W     = 16;
  localparam int SMASK_W   = 12;
  localparam int PRIO_W    = 4;
  localparam int POS_W     = 10;
  localparam int MCOUNT_W  = 8;
  localparam int PAIR_W    = 11;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_HIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;

  // result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register indexes, byte address 4*index
  localparam logic [1:0] REG_REF_TIME   = 2'd0;
  localparam logic [1:0] REG_LOW_WIN    = 2'd1;
  localparam logic [1:0] REG_HIGH_WIN   = 2'd2;
  localparam logic [1:0] REG_STAT_MASK  = 2'd3;

  localparam logic [TIME_W-1:0]  REF_TIME_RST  = 31'h7FFF_0640;  // -63936
  localparam logic [WIN_W-1:0]   WIN_RST       = 16'd320;
  localparam logic [SMASK_W-1:0] STAT_MASK_RST = 12'd0;

  localparam logic [PRIO_W-1:0] PRIO_MATCH = 4'd9;

  // edge mask to priority
  localparam logic [PRIO_W-1:0] PRIO_TABLE [16] = '{
    4'd0, 4'd4, 4'd5, 4'd10, 4'd2, 4'd7, 4'd11, 4'd13,
    4'd1, 4'd12, 4'd6, 4'd14, 4'd3, 4'd8, 4'd9, 4'd15
  };

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [STATION_W-1:0] station;
    logic [CHAN_W-1:0]    channel_id;
    logic [TIME_W-1:0]    hit_time;
    logic [EDGE_W-1:0]    edge_mask;
    logic [SLOT_W-1:0]    entry_slot;
    logic                 entry_valid;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0]  reference_time;
    logic [WIN_W-1:0]   low_window;
    logic [WIN_W-1:0]   high_window;
    logic [SMASK_W-1:0] station_mask;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [POS_W-1:0]    hit_position;
    logic [CHAN_W-1:0]   matched_channel;
    logic                has_match;
    logic [PRIO_W-1:0]   best_priority;
    logic [MCOUNT_W-1:0] match_count;
    logic [PAIR_W-1:0]   low_pair_count;
    logic [PAIR_W-1:0]   high_pair_count;
    logic [DELTA_W-1:0]  best_delta;
    logic                best_found;
    logic [EDGE_W-1:0]   best_edge;
  } result_t;

endpackage

FILE: src/veto_hit_time_matcher.sv
// Veto hit time matcher. One request is taken per clock unless the result
// side stalls: a hit (func 0), an event close (func 1) or a noisy-channel
// table load (func 2). A request is held in the input register, where the
// window, station mask and noisy-table compare and the event counter updates
// are all done in a single pass, and its result, if any (a match record or
// the event summary), is then written to the result register.
// Throughput is one request per cycle as long as results are taken; a stall
// on the result side holds the input register and then stalls requests.
// Registers on the APB port, byte addresses: 0x0 reference_time (31-bit
// signed), 0x4 low_window, 0x8 high_window, 0xC station_mask. Write them only
// while no request is in flight. Times are in units of 1/64 ns.
`include "assert_macros.svh"

module veto_hit_time_matcher import vhtm_pkg::*; #(
  parameter int NOISY_DEPTH = NOISY_DEPTH_DEF,
  parameter int MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int MAX_HITS    = MAX_HITS_DEF,
  parameter int STATIONS    = STATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                hit_valid,
  output logic                hit_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [STATION_W-1:0] station,
  input  logic [CHAN_W-1:0]   channel_id,
  input  logic signed [TIME_W-1:0] hit_time,
  input  logic [EDGE_W-1:0]   edge_mask,
  input  logic [SLOT_W-1:0]   entry_slot,
  input  logic                entry_valid,

  output logic                res_valid,
  input  logic                res_stall,
  output logic                kind,
  output logic [POS_W-1:0]    hit_position,
  output logic [CHAN_W-1:0]   matched_channel,
  output logic                has_match,
  output logic [PRIO_W-1:0]   best_priority,
  output logic [MCOUNT_W-1:0] match_count,
  output logic [PAIR_W-1:0]   low_pair_count,
  output logic [PAIR_W-1:0]   high_pair_count,
  output logic signed [DELTA_W-1:0] best_delta,
  output logic                best_found,
  output logic [EDGE_W-1:0]   best_edge,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t    cfg;
  logic    cfg_wr;

  logic    s1_valid;
  req_t    s1_req;
  logic    s1_adv;
  logic    hit_take;

  logic    noisy;
  logic    emit;
  result_t result;
  result_t res;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reference_time <= REF_TIME_RST;
      cfg.low_window     <= WIN_RST;
      cfg.high_window    <= WIN_RST;
      cfg.station_mask   <= STAT_MASK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_REF_TIME:  cfg.reference_time <= pwdata[TIME_W-1:0];
        REG_LOW_WIN:   cfg.low_window     <= pwdata[WIN_W-1:0];
        REG_HIGH_WIN:  cfg.high_window    <= pwdata[WIN_W-1:0];
        REG_STAT_MASK: cfg.station_mask   <= pwdata[SMASK_W-1:0];
        default:       cfg.station_mask   <= cfg.station_mask;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_REF_TIME:  prdata = {cfg.reference_time[TIME_W-1], cfg.reference_time};
      REG_LOW_WIN:   prdata = {16'd0, cfg.low_window};
      REG_HIGH_WIN:  prdata = {16'd0, cfg.high_window};
      REG_STAT_MASK: prdata = {20'd0, cfg.station_mask};
      default:       prdata = '0;
    endcase
  end

  // input register: advance whenever the result register can take a slot
  assign s1_adv    = s1_valid && (!res_valid || !res_stall);
  assign hit_stall = s1_valid && res_valid && res_stall;
  assign hit_take  = hit_valid && !hit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hit_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_take) begin
      s1_req.func        <= func;
      s1_req.station     <= station;
      s1_req.channel_id  <= channel_id;
      s1_req.hit_time    <= hit_time;
      s1_req.edge_mask   <= edge_mask;
      s1_req.entry_slot  <= entry_slot;
      s1_req.entry_valid <= entry_valid;
    end
  end

  vhtm_noisy_table #(
    .NOISY_DEPTH (NOISY_DEPTH)
  ) u_noisy (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (s1_adv && (s1_req.func == FUNC_LOAD)),
    .wr_slot     (s1_req.entry_slot),
    .wr_valid    (s1_req.entry_valid),
    .wr_chan     (s1_req.channel_id),
    .lookup_chan (s1_req.channel_id),
    .noisy       (noisy)
  );

  vhtm_event_acc #(
    .MAX_MATCHES (MAX_MATCHES),
    .MAX_HITS    (MAX_HITS),
    .STATIONS    (STATIONS)
  ) u_acc (
    .clk    (clk),
    .rst    (rst),
    .proc   (s1_adv),
    .req    (s1_req),
    .cfg    (cfg),
    .noisy  (noisy),
    .emit   (emit),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      res <= result;
    end
  end

  assign kind            = res.kind;
  assign hit_position    = res.hit_position;
  assign matched_channel = res.matched_channel;
  assign has_match       = res.has_match;
  assign best_priority   = res.best_priority;
  assign match_count     = res.match_count;
  assign low_pair_count  = res.low_pair_count;
  assign high_pair_count = res.high_pair_count;
  assign best_delta      = res.best_delta;
  assign best_found      = res.best_found;
  assign best_edge       = res.best_edge;

  `VHTM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!s1_valid && !res_valid), "pipeline not empty after reset")
  `VHTM_ASSERT(a_stall_full, clk, rst, hit_stall |-> (s1_valid && res_valid && res_stall), "request stalled with room to advance")
  `VHTM_ASSERT(a_close_summary, clk, rst, (s1_adv && (s1_req.func == FUNC_CLOSE)) |=> (res_valid && (kind == KIND_SUMMARY)), "event close gave no summary")
  `VHTM_ASSERT(a_summary_match, clk, rst, (res_valid && (kind == KIND_SUMMARY)) |-> (has_match == (best_priority >= PRIO_MATCH)), "summary match flag disagrees with priority")
  `VHTM_ASSERT(a_summary_best, clk, rst, (res_valid && (kind == KIND_SUMMARY) && !best_found) |-> ((best_delta == '0) && (best_edge == '0)), "closest hit fields set without a closest hit")

endmodule

FILE: src/vhtm_noisy_table.sv
module vhtm_noisy_table import vhtm_pkg::*; #(
  parameter int NOISY_DEPTH = NOISY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic              wr_valid,
  input  logic [CHAN_W-1:0] wr_chan,
  input  logic [CHAN_W-1:0] lookup_chan,
  output logic              noisy
);

  logic [NOISY_DEPTH-1:0] entry_valid;
  logic [CHAN_W-1:0]      entry_chan [NOISY_DEPTH];

  // a slot at or above the depth matches no entry, so the write is dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < NOISY_DEPTH; i++) begin
      if (rst) begin
        entry_valid[i] <= 1'b0;
      end else if (wr_en && (32'(wr_slot) == i)) begin
        entry_valid[i] <= wr_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NOISY_DEPTH; i++) begin
      if (wr_en && (32'(wr_slot) == i)) begin
        entry_chan[i] <= wr_chan;
      end
    end
  end

  always_comb begin
    noisy = 1'b0;
    for (int i = 0; i < NOISY_DEPTH; i++) begin
      if (entry_valid[i] && (entry_chan[i] == lookup_chan)) begin
        noisy = 1'b1;
      end
    end
  end

endmodule

FILE: src/vhtm_event_acc.sv
module vhtm_event_acc import vhtm_pkg::*; #(
  parameter int MAX_MATCHES = MAX_MATCHES_DEF,
  parameter int MAX_HITS    = MAX_HITS_DEF,
  parameter int STATIONS    = STATIONS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    proc,
  input  req_t    req,
  input  cfg_t    cfg,
  input  logic    noisy,
  output logic    emit,
  output result_t result
);

  localparam int HC_W = $clog2(MAX_HITS + 1);
  localparam int MC_W = $clog2(MAX_MATCHES + 1);

  logic [HC_W-1:0]    hit_counter;
  logic [MC_W-1:0]    match_counter;
  logic [HC_W-1:0]    low_pairs;
  logic [HC_W-1:0]    high_pairs;
  logic [PRIO_W-1:0]  top_priority;
  logic [DELTA_W-1:0] closest_delta;
  logic [DELTA_W-1:0] closest_mag;
  logic [EDGE_W-1:0]  closest_edge;
  logic               closest_valid;

  logic               is_hit;
  logic               is_close;
  logic               room;
  logic [DELTA_W-1:0] dt;
  logic [DELTA_W-1:0] adt;
  logic [WIN_W-1:0]   win;
  logic               in_window;
  logic               station_ok;
  logic [15:0]        mask16;
  logic               masked;
  logic               accept;
  logic [PRIO_W-1:0]  prio;
  logic               high_prio;
  logic               closer;
  logic               can_match;
  logic               match_emit;
  logic [31:0]        pos_ext;
  logic [31:0]        mc_ext;
  logic [31:0]        lp_ext;
  logic [31:0]        hp_ext;

  assign is_hit   = req.func == FUNC_HIT;
  assign is_close = req.func == FUNC_CLOSE;
  assign room     = hit_counter < HC_W'(MAX_HITS);

  // difference of two 31-bit signed values always fits 32 bits
  assign dt  = {req.hit_time[TIME_W-1], req.hit_time}
             - {cfg.reference_time[TIME_W-1], cfg.reference_time};
  assign adt = dt[DELTA_W-1] ? (~dt + 32'd1) : dt;

  assign win       = (req.edge_mask[1:0] == 2'b11) ? cfg.high_window : cfg.low_window;
  assign in_window = adt <= {16'd0, win};

  assign station_ok = (req.station != '0) && ({1'b0, req.station} <= 5'(STATIONS));
  // stations above the mask read a zero bit; station 0 is already rejected
  assign mask16     = {4'd0, cfg.station_mask};
  assign masked     = mask16[req.station - 4'd1];

  assign accept = proc && is_hit && room && station_ok && !masked && in_window && !noisy;

  assign prio       = PRIO_TABLE[req.edge_mask];
  assign high_prio  = prio >= PRIO_MATCH;
  assign closer     = !closest_valid || (adt < closest_mag);
  assign can_match  = match_counter < MC_W'(MAX_MATCHES);
  assign match_emit = accept && high_prio && can_match;

  assign emit = (proc && is_close) || match_emit;

  assign pos_ext = 32'(hit_counter);
  assign mc_ext  = 32'(match_counter);
  assign lp_ext  = 32'(low_pairs);
  assign hp_ext  = 32'(high_pairs);

  always_comb begin
    result = '0;
    if (is_close) begin
      result.kind            = KIND_SUMMARY;
      result.has_match       = top_priority >= PRIO_MATCH;
      result.best_priority   = top_priority;
      result.match_count     = mc_ext[MCOUNT_W-1:0];
      result.low_pair_count  = lp_ext[PAIR_W-1:0];
      result.high_pair_count = hp_ext[PAIR_W-1:0];
      if (closest_valid) begin
        result.best_delta = closest_delta;
        result.best_found = 1'b1;
        result.best_edge  = closest_edge;
      end
    end else begin
      result.kind            = KIND_MATCH;
      result.hit_position    = pos_ext[POS_W-1:0];
      result.matched_channel = req.channel_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (proc && is_close)) begin
      hit_counter   <= '0;
      match_counter <= '0;
      low_pairs     <= '0;
      high_pairs    <= '0;
      top_priority  <= '0;
      closest_delta <= '0;
      closest_mag   <= '0;
      closest_edge  <= '0;
      closest_valid <= 1'b0;
    end else begin
      if (proc && is_hit && room) begin
        hit_counter <= hit_counter + HC_W'(1);
      end
      if (accept) begin
        if (req.edge_mask[3] && req.edge_mask[0]) begin
          low_pairs <= low_pairs + HC_W'(1);
        end
        if (req.edge_mask[2] && req.edge_mask[1]) begin
          high_pairs <= high_pairs + HC_W'(1);
        end
        if (prio > top_priority) begin
          top_priority <= prio;
        end
        // ties keep the earlier hit
        if (high_prio && closer) begin
          closest_delta <= dt;
          closest_mag   <= adt;
          closest_edge  <= req.edge_mask;
          closest_valid <= 1'b1;
        end
      end
      if (match_emit) begin
        match_counter <= match_counter + MC_W'(1);
      end
    end
  end

endmodule
